// File: hdl/svpwm_pkg.sv
// Package for the SVPWM duty calculator: payload structs, constants, sector table.
// No dependencies.
`timescale 1ns / 1ps
package svpwm_pkg;
  localparam int VoltWidth = 16;
  localparam int Sqrt3Q16 = 113512;
  localparam logic [15:0] HalfQ15 = 16'd16384;
  localparam logic [16:0] OneQ15 = 17'd32768;

  typedef struct packed {
    logic signed [VoltWidth-1:0] v_alpha;
    logic signed [VoltWidth-1:0] v_beta;
    logic [VoltWidth-1:0] bus_voltage;
  } svpwm_in_t;

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0] sector_number;
  } svpwm_out_t;

  // Map the projection sign code to a sector, zero for impossible codes.
  function automatic logic [2:0] code_to_sector(input logic [2:0] code);
    logic [2:0] s;
    case (code)
      3'd1: s = 3'd2;
      3'd2: s = 3'd6;
      3'd3: s = 3'd1;
      3'd4: s = 3'd4;
      3'd5: s = 3'd3;
      3'd6: s = 3'd5;
      default: s = 3'd0;
    endcase
    return s;
  endfunction
endpackage

// File: hdl/svpwm_divider.sv
// Pipelined restoring divider: one quotient bit per stage, two quotients in lockstep.
// No dependencies; the quotients are Q15 fractions.
`timescale 1ns / 1ps
module svpwm_divider #(
  parameter int W = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [W-1:0]  num1,
  input  logic [W-1:0]  num2,
  input  logic [W-1:0]  den,
  input  logic [21:0]   tag,
  output logic          out_valid,
  output logic [15:0]   quo1,
  output logic [15:0]   quo2,
  output logic [21:0]   out_tag
);
  localparam int Steps = 17;  // integer bit, 15 fraction bits, rounding step

  logic             vld [1:Steps];
  logic [W:0]       r1  [1:Steps];
  logic [W:0]       r2  [1:Steps];
  logic [W-1:0]     dd  [1:Steps];
  logic [16:0]      q1  [1:Steps];
  logic [16:0]      q2  [1:Steps];
  logic [21:0]      tg  [1:Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic          v_in;
    logic [W:0]    r1_in, r2_in;
    logic [W-1:0]  d_in;
    logic [16:0]   q1_in, q2_in;
    logic [21:0]   t_in;
    logic [W+1:0]  s1, s2;
    logic          b1, b2;

    if (i == 0) begin : g_src
      assign v_in  = in_valid;
      assign r1_in = {1'b0, num1};
      assign r2_in = {1'b0, num2};
      assign d_in  = den;
      assign q1_in = '0;
      assign q2_in = '0;
      assign t_in  = tag;
    end else begin : g_src
      assign v_in  = vld[i];
      assign r1_in = r1[i];
      assign r2_in = r2[i];
      assign d_in  = dd[i];
      assign q1_in = q1[i];
      assign q2_in = q2[i];
      assign t_in  = tg[i];
    end

    always_comb begin
      // First step compares r with den, later steps compare 2r, last is rounding 2r>=den.
      s1 = (i == 0) ? {1'b0, r1_in} : {r1_in, 1'b0};
      s2 = (i == 0) ? {1'b0, r2_in} : {r2_in, 1'b0};
      b1 = s1 >= {2'b0, d_in};
      b2 = s2 >= {2'b0, d_in};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= v_in;
      end
      r1[i+1] <= (W+1)'(b1 ? s1 - {2'b0, d_in} : s1);
      r2[i+1] <= (W+1)'(b2 ? s2 - {2'b0, d_in} : s2);
      dd[i+1] <= d_in;
      tg[i+1] <= t_in;
      if (i == Steps - 1) begin
        q1[i+1] <= q1_in + {16'd0, b1};
        q2[i+1] <= q2_in + {16'd0, b2};
      end else begin
        q1[i+1] <= {q1_in[15:0], b1};
        q2[i+1] <= {q2_in[15:0], b2};
      end
    end
  end

  assign out_valid = vld[Steps];
  assign quo1      = q1[Steps][15:0];
  assign quo2      = q2[Steps][15:0];
  assign out_tag   = tg[Steps];
endmodule

// File: hdl/svpwm_duty_calculator.sv
// Top level of the SVPWM duty calculator: projection, dwell, divider, duty stages.
// Depends on svpwm_pkg and svpwm_divider.
`timescale 1ns / 1ps
// Takes one reference vector every clock cycle; busy is tied low since the block
// never stalls. Each result appears on result with done high for one cycle,
// after the projection and dwell selection stages, the 17 stages of the
// pipelined divider (one quotient bit each, plus rounding), and the stages
// that form the centered duties. The receiver must take every result as
// it appears. A zero vector or zero bus voltage gives 0.5 on all phases and
// sector 0; overmodulated vectors are scaled so the dwell times fill the period.
module svpwm_duty_calculator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  svpwm_pkg::svpwm_in_t   operand,
  output logic                   done,
  output svpwm_pkg::svpwm_out_t  result
);
  localparam int VOLT_WIDTH = svpwm_pkg::VoltWidth;
  localparam int PW = VOLT_WIDTH + 21;  // width of signed projection numerators
  localparam int NW = PW + 1;            // width of n1+n2 and the denominator

  assign busy = 1'b0;

  // Stage 1: scale alpha and beta.
  logic                   s1_valid;
  logic signed [PW-1:0]   s1_a, s1_b;
  logic [VOLT_WIDTH-1:0]  s1_vdc;
  logic                   s1_bpos;
  logic signed [VOLT_WIDTH-1:0] va, vb;

  assign va = operand.v_alpha[VOLT_WIDTH-1:0];
  assign vb = operand.v_beta[VOLT_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_a    <= PW'(va) * PW'(signed'(3 * 65536));
    s1_b    <= PW'(vb) * PW'(signed'(svpwm_pkg::Sqrt3Q16));
    s1_vdc  <= operand.bus_voltage[VOLT_WIDTH-1:0];
    s1_bpos <= (vb > 0);
  end

  // Stage 2: projections, sector, dwell numerators.
  logic signed [PW-1:0] x1, x2, x3;
  logic [2:0]           sec;
  logic [NW-1:0]        n1, n2;
  logic                 zero_case;

  function automatic logic [NW-1:0] clampp(input logic signed [PW-1:0] x);
    return (x > 0) ? NW'(unsigned'(x)) : '0;
  endfunction

  always_comb begin
    x1 = s1_b <<< 1;
    x2 = s1_a - s1_b;
    x3 = -s1_a - s1_b;
    sec = svpwm_pkg::code_to_sector({x3 > 0, x2 > 0, s1_bpos});
    zero_case = (s1_vdc == '0) || (sec == 3'd0);
    case (sec)
      3'd1: begin n1 = clampp(x2);  n2 = clampp(x1);  end
      3'd2: begin n1 = clampp(-x3); n2 = clampp(-x2); end
      3'd3: begin n1 = clampp(x1);  n2 = clampp(x3);  end
      3'd4: begin n1 = clampp(-x2); n2 = clampp(-x1); end
      3'd5: begin n1 = clampp(x3);  n2 = clampp(x2);  end
      default: begin n1 = clampp(-x1); n2 = clampp(-x3); end
    endcase
  end

  logic          s2_valid, s2_zero;
  logic [2:0]    s2_sec;
  logic [NW-1:0] s2_n1, s2_sum, s2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_sec  <= sec;
    s2_zero <= zero_case;
    s2_n1   <= n1;
    s2_sum  <= n1 + n2;
    s2_d    <= NW'({s1_vdc, 17'd0});
  end

  // Denominator: larger of bus term and dwell sum (overmodulation scaling).
  logic [NW-1:0] den;
  assign den = (s2_sum > s2_d) ? s2_sum : s2_d;

  logic        dv_valid;
  logic [15:0] q_t1, q_sum;
  logic [21:0] dv_tag;

  svpwm_divider #(.W(NW)) u_div (
    .clk(clk), .rst(rst),
    .in_valid(s2_valid),
    .num1(s2_n1), .num2(s2_sum), .den(s2_zero ? NW'(1) : den),
    .tag({18'd0, s2_zero, s2_sec}),
    .out_valid(dv_valid), .quo1(q_t1), .quo2(q_sum), .out_tag(dv_tag)
  );

  // Stage A: half zero time and second dwell.
  logic        s3_valid, s3_zero;
  logic [2:0]  s3_sec;
  logic [15:0] s3_t1, s3_t2, s3_sum, s3_h;
  logic [16:0] zt;
  assign zt = svpwm_pkg::OneQ15 - {1'b0, q_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= dv_valid;
    end
    s3_zero <= dv_tag[3];
    s3_sec  <= dv_tag[2:0];
    s3_t1   <= q_t1;
    s3_sum  <= q_sum;
    s3_t2   <= q_sum - q_t1;
    s3_h    <= zt[16:1];
  end

  // Stage B: centered duties by sector, or 0.5 on all phases in the zero case.
  svpwm_pkg::svpwm_out_t res_next;
  always_comb begin
    res_next.sector_number = s3_sec;
    case (s3_sec)
      3'd1: begin res_next.duty_a = s3_h + s3_sum; res_next.duty_b = s3_h + s3_t2;
                  res_next.duty_c = s3_h; end
      3'd2: begin res_next.duty_a = s3_h + s3_t1; res_next.duty_b = s3_h + s3_sum;
                  res_next.duty_c = s3_h; end
      3'd3: begin res_next.duty_a = s3_h; res_next.duty_b = s3_h + s3_sum;
                  res_next.duty_c = s3_h + s3_t2; end
      3'd4: begin res_next.duty_a = s3_h; res_next.duty_b = s3_h + s3_t1;
                  res_next.duty_c = s3_h + s3_sum; end
      3'd5: begin res_next.duty_a = s3_h + s3_t2; res_next.duty_b = s3_h;
                  res_next.duty_c = s3_h + s3_sum; end
      default: begin res_next.duty_a = s3_h + s3_sum; res_next.duty_b = s3_h;
                  res_next.duty_c = s3_h + s3_t1; end
    endcase
    if (s3_zero) begin
      res_next.duty_a = svpwm_pkg::HalfQ15;
      res_next.duty_b = svpwm_pkg::HalfQ15;
      res_next.duty_c = svpwm_pkg::HalfQ15;
      res_next.sector_number = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
    result <= res_next;
  end

  a_sec_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.sector_number <= 3'd6) else $error("sector out of range");
  a_zero_half: assert property (@(posedge clk) disable iff (rst)
    done && result.sector_number == 3'd0 |-> result.duty_a == svpwm_pkg::HalfQ15)
    else $error("zero vector duty");
  a_duty_max: assert property (@(posedge clk) disable iff (rst)
    done |-> result.duty_a <= 16'd32768 && result.duty_b <= 16'd32768
             && result.duty_c <= 16'd32768) else $error("duty above one");
endmodule

// File: tb/svpwm_checker.sv
// Scoreboard for the SVPWM duty calculator: predicts each result from the
// accepted vector and compares it with the block's output. Depends on svpwm_pkg.
`timescale 1ns / 1ps
module svpwm_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  svpwm_pkg::svpwm_in_t  operand,
  input  logic                  done,
  input  svpwm_pkg::svpwm_out_t result,
  output int                    fail_count,
  output int                    pending_count,
  output int                    result_count
);
  svpwm_pkg::svpwm_out_t duty_queue[$];

  // Round half up of num * 2^15 / den, with num <= den.
  function automatic longint q15_fraction(longint num, longint den);
    longint q;
    longint r;
    q = (num >= den) ? 1 : 0;
    r = num - q * den;
    for (int i = 0; i < 15; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    if (2 * r >= den) q = q + 1;
    return q;
  endfunction

  function automatic longint pos(longint x);
    return (x > 0) ? x : 0;
  endfunction

  function automatic svpwm_pkg::svpwm_out_t predict_duties(svpwm_pkg::svpwm_in_t v);
    svpwm_pkg::svpwm_out_t o;
    longint va, vb, vdc, pa, pb, x1, x2, x3, n1, n2, den, t1, ts, t2, h;
    logic [2:0] code;
    logic [2:0] sec;
    va = longint'(v.v_alpha);
    vb = longint'(v.v_beta);
    vdc = longint'({1'b0, v.bus_voltage});
    pa = 3 * va * 65536;
    pb = vb * 113512;
    x1 = 2 * pb;
    x2 = pa - pb;
    x3 = -pa - pb;
    code = {x3 > 0, x2 > 0, vb > 0};
    case (code)
      3'd3: sec = 3'd1;
      3'd1: sec = 3'd2;
      3'd5: sec = 3'd3;
      3'd4: sec = 3'd4;
      3'd6: sec = 3'd5;
      3'd2: sec = 3'd6;
      default: sec = 3'd0;
    endcase
    if (vdc == 0 || sec == 0) begin
      o.duty_a = 16'd16384;
      o.duty_b = 16'd16384;
      o.duty_c = 16'd16384;
      o.sector_number = 3'd0;
      return o;
    end
    case (sec)
      3'd1: begin n1 = pos(x2); n2 = pos(x1); end
      3'd2: begin n1 = pos(-x3); n2 = pos(-x2); end
      3'd3: begin n1 = pos(x1); n2 = pos(x3); end
      3'd4: begin n1 = pos(-x2); n2 = pos(-x1); end
      3'd5: begin n1 = pos(x3); n2 = pos(x2); end
      default: begin n1 = pos(-x1); n2 = pos(-x3); end
    endcase
    den = vdc * 131072;
    if (n1 + n2 > den) den = n1 + n2;
    t1 = q15_fraction(n1, den);
    ts = q15_fraction(n1 + n2, den);
    t2 = ts - t1;
    h = (32768 - ts) >>> 1;
    case (sec)
      3'd1: begin
        o.duty_a = 16'(h + ts); o.duty_b = 16'(h + t2); o.duty_c = 16'(h);
      end
      3'd2: begin
        o.duty_a = 16'(h + t1); o.duty_b = 16'(h + ts); o.duty_c = 16'(h);
      end
      3'd3: begin
        o.duty_a = 16'(h); o.duty_b = 16'(h + ts); o.duty_c = 16'(h + t2);
      end
      3'd4: begin
        o.duty_a = 16'(h); o.duty_b = 16'(h + t1); o.duty_c = 16'(h + ts);
      end
      3'd5: begin
        o.duty_a = 16'(h + t2); o.duty_b = 16'(h); o.duty_c = 16'(h + ts);
      end
      default: begin
        o.duty_a = 16'(h + ts); o.duty_b = 16'(h); o.duty_c = 16'(h + t1);
      end
    endcase
    o.sector_number = sec;
    return o;
  endfunction

  assign pending_count = duty_queue.size();

  always @(posedge clk) begin
    svpwm_pkg::svpwm_out_t exp_duty;
    if (rst) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (done) begin
        result_count <= result_count + 1;
        if (duty_queue.size() == 0) begin
          $error("result with no vector outstanding");
          fail_count <= fail_count + 1;
        end else begin
          exp_duty = duty_queue.pop_front();
          if (result !== exp_duty) begin
            fail_count <= fail_count + 1;
            if (result.duty_a !== exp_duty.duty_a)
              $error("duty_a expected %0d got %0d", exp_duty.duty_a, result.duty_a);
            if (result.duty_b !== exp_duty.duty_b)
              $error("duty_b expected %0d got %0d", exp_duty.duty_b, result.duty_b);
            if (result.duty_c !== exp_duty.duty_c)
              $error("duty_c expected %0d got %0d", exp_duty.duty_c, result.duty_c);
            if (result.sector_number !== exp_duty.sector_number)
              $error("sector_number expected %0d got %0d",
                     exp_duty.sector_number, result.sector_number);
          end
        end
      end
      // Push after the pop so a result can never be matched against its own vector's entry.
      if (start && !busy) duty_queue.push_back(predict_duties(operand));
    end
  end
endmodule

// File: tb/tb.sv
// Testbench top for the SVPWM duty calculator: clock, reset, directed and
// random reference vectors, watchdog and verdict. Depends on svpwm_pkg and svpwm_checker.
`timescale 1ns / 1ps
module tb;
  localparam int RandomItems = 800;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles = 40;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  svpwm_pkg::svpwm_in_t  operand;
  logic                  done;
  svpwm_pkg::svpwm_out_t result;
  int         fail_count;
  int         pending_count;
  int         result_count;
  int         idle_cycles;
  int         item_count;
  int         sender_idle_pct;

  svpwm_duty_calculator uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operand(operand), .done(done), .result(result)
  );

  svpwm_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operand(operand),
    .done(done), .result(result), .fail_count(fail_count),
    .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles with no item accepted on either side; give up at the limit.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no activity for %0d cycles", WatchdogLimit);
      $display("svpwm_duty_calculator: mismatch");
      $finish;
    end
  end

  // Offer one vector, holding start until accepted; optionally idle first.
  task automatic send_vector(input logic [15:0] va, input logic [15:0] vb,
                             input logic [15:0] vdc);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operand <= '{v_alpha: va, v_beta: vb, bus_voltage: vdc};
    @(posedge clk);
    while (busy) @(posedge clk);
    item_count++;
  endtask

  // Pick a random vector: mostly inside the hexagon, some overmodulated,
  // some with extreme or tiny values, an occasional zero case.
  task automatic send_random();
    logic [15:0] va, vb, vdc;
    int kind;
    kind = $urandom_range(9, 0);
    vdc = (kind < 5) ? 16'($urandom_range(65535, 1000)) : 16'($urandom());
    if (kind < 5) begin
      va = 16'($signed($urandom_range(2 * (vdc / 3), 0)) - $signed(vdc / 3));
      vb = 16'($signed($urandom_range(2 * (vdc / 3), 0)) - $signed(vdc / 3));
    end else if (kind < 8) begin
      va = 16'($urandom());
      vb = 16'($urandom());
    end else if (kind == 8) begin
      va = 16'($signed($urandom_range(8, 0)) - 4);
      vb = 16'($signed($urandom_range(8, 0)) - 4);
      vdc = 16'($urandom_range(4, 0));
    end else begin
      va = ($urandom_range(1, 0) != 0) ? 16'h0000 : 16'($urandom());
      vb = ($urandom_range(1, 0) != 0) ? 16'h0000 : 16'($urandom());
      if ($urandom_range(1, 0) != 0) vdc = 16'h0000;
    end
    send_vector(va, vb, vdc);
  endtask

  initial begin
    int wait_cycles;
    rst = 1'b1;
    start = 1'b0;
    operand = '0;
    item_count = 0;
    sender_idle_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero vector, zero bus voltage, every sector, overmodulation,
    // field extremes and an odd zero time.
    send_vector(16'd0, 16'd0, 16'd1000);
    send_vector(16'd0, 16'd0, 16'd0);
    send_vector(16'd300, 16'd200, 16'd0);
    send_vector(16'd300, 16'd100, 16'd1000);
    send_vector(16'd0, 16'd300, 16'd1000);
    send_vector(-16'sd300, 16'd100, 16'd1000);
    send_vector(-16'sd300, -16'sd100, 16'd1000);
    send_vector(16'd0, -16'sd300, 16'd1000);
    send_vector(16'd300, -16'sd100, 16'd1000);
    send_vector(16'd300, 16'd0, 16'd1000);
    send_vector(-16'sd300, 16'd0, 16'd1000);
    send_vector(16'h7FFF, 16'h7FFF, 16'd1);
    send_vector(16'h8000, 16'h8000, 16'hFFFF);
    send_vector(16'h7FFF, 16'h8000, 16'hFFFF);
    send_vector(16'h8000, 16'h7FFF, 16'd100);
    send_vector(16'd1, 16'd0, 16'hFFFF);
    send_vector(16'd0, 16'd1, 16'hFFFF);
    send_vector(16'hFFFF, 16'hFFFF, 16'd3);
    send_vector(16'd1234, 16'd567, 16'd4321);
    send_vector(16'd30000, 16'd1, 16'd30000);

    // Random phases: sender idles 9 percent, then 81 percent, then never.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 9 : (phase == 1) ? 81 : 0;
      for (int i = 0; i < RandomItems / 3; i++) send_random();
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < WatchdogLimit) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d vectors (directed sectors, zero and overmodulated cases, random)",
             item_count);
    $display("checked %0d results, %0d failures, %0d left outstanding",
             result_count, fail_count, pending_count);
    if (fail_count == 0 && pending_count == 0)
      $display("svpwm_duty_calculator: match");
    else
      $display("svpwm_duty_calculator: mismatch");
    $finish;
  end
endmodule
